### sv/lcrm_pkg.sv
// Package for the link counter rate meter: types, constants and sequencer states.
package lcrm_pkg;

    localparam int DATA_W          = 64;
    localparam int CTR_W_DEFAULT   = 64;
    localparam int EPOCH_W_DEFAULT = 32;
    localparam int NUM_CTR         = 8;
    localparam int CTR_IDX_W       = $clog2(NUM_CTR);
    localparam int NUM_RATES       = 4;
    localparam int RATE_IDX_W      = $clog2(NUM_RATES);
    localparam int NS_W            = 30;
    localparam int HALF_W          = DATA_W / 2;
    localparam int PART_W          = HALF_W + NS_W;
    localparam int PROD_W          = DATA_W + NS_W;
    localparam int QUO_CNT_W       = $clog2(DATA_W);
    localparam int CFG_INDEX_W     = 4;
    localparam int BYTE_SHIFT      = 3;

    localparam logic [NS_W-1:0]   NS_PER_SEC    = NS_W'(1000000000);
    localparam logic [DATA_W-1:0] MAX_GAP_RESET = 64'd3000000000;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_FORWARD_IS_RX = 4'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_GAP_NS    = 4'd1;

    // gap codes
    localparam logic [2:0] GAP_NONE     = 3'd0;
    localparam logic [2:0] GAP_INVALID  = 3'd1;
    localparam logic [2:0] GAP_FIRST    = 3'd2;
    localparam logic [2:0] GAP_IDENTITY = 3'd3;
    localparam logic [2:0] GAP_TIME     = 3'd4;
    localparam logic [2:0] GAP_RESET    = 3'd5;

    // counter order inside the sample
    localparam logic [CTR_IDX_W-1:0] CTR_LAST = CTR_IDX_W'(NUM_CTR - 1);
    localparam logic [RATE_IDX_W-1:0] RATE_LAST = RATE_IDX_W'(NUM_RATES - 1);

    typedef struct packed {
        logic        sample_valid;
        logic [3:0]  invalid_reason;
        logic [63:0] identity_tag;
        logic [63:0] timestamp_ns;
        logic [63:0] rx_bytes;
        logic [63:0] tx_bytes;
        logic [63:0] rx_packets;
        logic [63:0] tx_packets;
        logic [63:0] rx_errors;
        logic [63:0] tx_errors;
        logic [63:0] rx_dropped;
        logic [63:0] tx_dropped;
    } sample_t;

    typedef struct packed {
        logic [2:0]  gap_code;
        logic [3:0]  reason_echo;
        logic        rates_valid;
        logic [63:0] forward_bits_rate;
        logic [63:0] reverse_bits_rate;
        logic [63:0] forward_packet_rate;
        logic [63:0] reverse_packet_rate;
        logic [31:0] epoch_count;
    } result_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLASSIFY,
        ST_TIME,
        ST_TCMP,
        ST_SCAN,
        ST_DELTA,
        ST_MUL,
        ST_DIV,
        ST_DONE
    } state_t;

endpackage

### sv/link_counter_rate_meter.sv
// Top level of the link counter rate meter: sequencer, sample state and result register.
//
//  channel  | direction | handshake           | payload
//  smp      | in        | smp_valid/smp_stall | lcrm_pkg::sample_t
//  res      | out       | res_valid/res_stall | lcrm_pkg::result_t
//  cfg      | in        | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// A sample with an early gap (invalid, first, identity) ends after the classify step,
// one that fails the time or counter checks after the counter scan; a rated sample
// runs a multiply and a division on the single bit-serial divider for each of its
// four rates, and a saturated division ends without iterating.
// smp_stall stays high from the transaction until the result is loaded into the
// output register; a stalled result blocks only the next sample's completion.
// rst_n clears control, the previous-valid flag and the epoch, and sets the configuration to its defaults.
module link_counter_rate_meter #(
    parameter int COUNTER_WIDTH = lcrm_pkg::CTR_W_DEFAULT,
    parameter int EPOCH_WIDTH   = lcrm_pkg::EPOCH_W_DEFAULT
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             smp_valid,
    output logic                             smp_stall,
    input  lcrm_pkg::sample_t                smp,
    output logic                             res_valid,
    input  logic                             res_stall,
    output lcrm_pkg::result_t                res,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [lcrm_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [lcrm_pkg::DATA_W-1:0]      cfg_data
);
    import lcrm_pkg::*;

    localparam int CW = COUNTER_WIDTH;
    localparam int EW = EPOCH_WIDTH;

    state_t state_reg;
    state_t state_next;

    // configuration
    logic              fwd_rx_reg;
    logic [DATA_W-1:0] max_gap_reg;

    // previous sample
    logic              prev_valid_reg;
    logic [DATA_W-1:0] prev_ident_reg;
    logic [DATA_W-1:0] prev_time_reg;
    logic [CW-1:0]     prev_ctr_reg [NUM_CTR];
    logic [EW-1:0]     epoch_reg;
    logic [EW-1:0]     epoch_next;

    // work registers
    sample_t               item_reg;
    logic [2:0]            gap_reg;
    logic [2:0]            gap_next;
    logic [DATA_W-1:0]     dt_reg;
    logic                  time_bad_reg;
    logic                  time_bad_next;
    logic                  dec_reg;
    logic                  dec_next;
    logic [CTR_IDX_W-1:0]  idx_reg;
    logic [CTR_IDX_W-1:0]  idx_next;
    logic [RATE_IDX_W-1:0] ridx_reg;
    logic [RATE_IDX_W-1:0] ridx_next;
    logic [DATA_W-1:0]     rate_reg [NUM_RATES];

    result_t res_reg;
    logic    res_valid_reg;

    logic [CW-1:0]        cur [NUM_CTR];
    logic [CTR_IDX_W-1:0] sel;
    logic [CW-1:0]        delta;
    logic [DATA_W:0]      time_diff;
    logic                 accept;
    logic                 load;
    logic                 mul_start;
    logic                 mul_done;
    logic [PROD_W-1:0]    product;
    logic [2*DATA_W-1:0]  dividend;
    logic                 div_start;
    logic                 div_done;
    logic [DATA_W-1:0]    quotient;
    logic [63:0]          epoch_ext;

    assign accept    = smp_valid && !smp_stall;
    assign smp_stall = (state_reg != ST_IDLE);
    assign cfg_ready = 1'b1;

    assign cur[0] = item_reg.rx_bytes[CW-1:0];
    assign cur[1] = item_reg.tx_bytes[CW-1:0];
    assign cur[2] = item_reg.rx_packets[CW-1:0];
    assign cur[3] = item_reg.tx_packets[CW-1:0];
    assign cur[4] = item_reg.rx_errors[CW-1:0];
    assign cur[5] = item_reg.tx_errors[CW-1:0];
    assign cur[6] = item_reg.rx_dropped[CW-1:0];
    assign cur[7] = item_reg.tx_dropped[CW-1:0];

    // rate order: forward bits, reverse bits, forward packets, reverse packets
    assign sel       = CTR_IDX_W'({ridx_reg[1], ridx_reg[0] ^ !fwd_rx_reg});
    assign delta     = cur[sel] - prev_ctr_reg[sel];
    assign time_diff = {1'b0, item_reg.timestamp_ns} - {1'b0, prev_time_reg};
    assign dividend  = ridx_reg[1] ? (2*DATA_W)'(product)
                                   : ((2*DATA_W)'(product) << BYTE_SHIFT);
    assign epoch_next = (gap_reg != GAP_NONE) ? epoch_reg + 1'b1 : epoch_reg;
    assign epoch_ext  = 64'(epoch_next);

    lcrm_mul u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .operand (DATA_W'(delta)),
        .done    (mul_done),
        .product (product)
    );

    lcrm_div u_div (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (div_start),
        .dividend_hi (dividend[2*DATA_W-1:DATA_W]),
        .dividend_lo (dividend[DATA_W-1:0]),
        .divisor     (dt_reg),
        .done        (div_done),
        .quotient    (quotient)
    );

    always_comb
    begin
        state_next    = state_reg;
        gap_next      = gap_reg;
        time_bad_next = time_bad_reg;
        dec_next      = dec_reg;
        idx_next      = idx_reg;
        ridx_next     = ridx_reg;
        mul_start     = 1'b0;
        div_start     = 1'b0;
        load          = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_CLASSIFY;
                end
            end
            ST_CLASSIFY:
            begin
                gap_next   = GAP_NONE;
                state_next = ST_TIME;
                if (!item_reg.sample_valid)
                begin
                    gap_next   = GAP_INVALID;
                    state_next = ST_DONE;
                end
                else if (!prev_valid_reg)
                begin
                    gap_next   = GAP_FIRST;
                    state_next = ST_DONE;
                end
                else if (item_reg.identity_tag != prev_ident_reg)
                begin
                    gap_next   = GAP_IDENTITY;
                    state_next = ST_DONE;
                end
            end
            ST_TIME:
            begin
                // borrow or zero means time did not move forward
                time_bad_next = time_diff[DATA_W] || (time_diff[DATA_W-1:0] == '0);
                state_next    = ST_TCMP;
            end
            ST_TCMP:
            begin
                time_bad_next = time_bad_reg || (dt_reg > max_gap_reg);
                dec_next      = 1'b0;
                idx_next      = '0;
                state_next    = ST_SCAN;
            end
            ST_SCAN:
            begin
                dec_next = dec_reg || (cur[idx_reg] < prev_ctr_reg[idx_reg]);
                idx_next = idx_reg + 1'b1;
                if (idx_reg == CTR_LAST)
                begin
                    ridx_next = '0;
                    if (dec_next)
                    begin
                        gap_next   = GAP_RESET;
                        state_next = ST_DONE;
                    end
                    else if (time_bad_reg)
                    begin
                        gap_next   = GAP_TIME;
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        state_next = ST_DELTA;
                    end
                end
            end
            ST_DELTA:
            begin
                mul_start  = 1'b1;
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                if (mul_done)
                begin
                    div_start  = 1'b1;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    ridx_next  = ridx_reg + 1'b1;
                    state_next = (ridx_reg == RATE_LAST) ? ST_DONE : ST_DELTA;
                end
            end
            ST_DONE:
            begin
                if (!res_valid_reg || !res_stall)
                begin
                    load       = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            fwd_rx_reg     <= 1'b1;
            max_gap_reg    <= MAX_GAP_RESET;
            prev_valid_reg <= 1'b0;
            epoch_reg      <= '0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_FORWARD_IS_RX: fwd_rx_reg  <= cfg_data[0];
                    CFG_MAX_GAP_NS:    max_gap_reg <= cfg_data;
                    default:
                    begin
                    end
                endcase
            end
            if (load)
            begin
                prev_valid_reg <= item_reg.sample_valid;
                epoch_reg      <= epoch_next;
                res_valid_reg  <= 1'b1;
            end
            else if (!res_stall)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        gap_reg      <= gap_next;
        time_bad_reg <= time_bad_next;
        dec_reg      <= dec_next;
        idx_reg      <= idx_next;
        ridx_reg     <= ridx_next;
        if (accept)
        begin
            item_reg <= smp;
        end
        if (state_reg == ST_TIME)
        begin
            dt_reg <= time_diff[DATA_W-1:0];
        end
        if (state_reg == ST_DIV && div_done)
        begin
            rate_reg[ridx_reg] <= quotient;
        end
        if (load)
        begin
            prev_ident_reg <= item_reg.identity_tag;
            prev_time_reg  <= item_reg.timestamp_ns;
            for (int i = 0; i < NUM_CTR; i++)
            begin
                prev_ctr_reg[i] <= cur[i];
            end
            res_reg.gap_code    <= gap_reg;
            res_reg.reason_echo <= (gap_reg == GAP_INVALID) ? item_reg.invalid_reason : 4'd0;
            res_reg.rates_valid <= (gap_reg == GAP_NONE);
            res_reg.forward_bits_rate   <= (gap_reg == GAP_NONE) ? rate_reg[0] : '0;
            res_reg.reverse_bits_rate   <= (gap_reg == GAP_NONE) ? rate_reg[1] : '0;
            res_reg.forward_packet_rate <= (gap_reg == GAP_NONE) ? rate_reg[2] : '0;
            res_reg.reverse_packet_rate <= (gap_reg == GAP_NONE) ? rate_reg[3] : '0;
            res_reg.epoch_count         <= epoch_ext[31:0];
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    a_rates_valid: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (res.rates_valid == (res.gap_code == GAP_NONE)))
        else $error("rates_valid disagrees with gap code");

    a_reason_echo: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res.gap_code != GAP_INVALID) |-> (res.reason_echo == 4'd0))
        else $error("reason echoed without a source-invalid gap");

    a_rates_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res.gap_code != GAP_NONE) |->
        (res.forward_bits_rate == '0 && res.reverse_bits_rate == '0 &&
         res.forward_packet_rate == '0 && res.reverse_packet_rate == '0))
        else $error("nonzero rate on a gap");

    a_epoch_step: assert property (@(posedge clk) disable iff (!rst_n)
        (load && gap_reg != GAP_NONE) |=> (epoch_reg == $past(epoch_reg) + 1'b1))
        else $error("epoch did not advance on a gap");

    a_mul_seq: assert property (@(posedge clk) disable iff (!rst_n)
        mul_done |-> (state_reg == ST_MUL))
        else $error("multiplier finished outside the multiply step");

endmodule

### sv/lcrm_mul.sv
// Counter delta times one second in ns, one 32 x 30 multiplier reused over two halves.
module lcrm_mul (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    input  logic [lcrm_pkg::DATA_W-1:0]           operand,
    output logic                                  done,
    output logic [lcrm_pkg::PROD_W-1:0]           product
);
    import lcrm_pkg::*;

    logic [DATA_W-1:0] a_reg;
    logic [PART_W-1:0] p_reg;
    logic [PROD_W-1:0] acc_reg;
    logic [1:0]        step_reg;
    logic [1:0]        step_next;
    logic              done_reg;
    logic [HALF_W-1:0] half;
    logic [PART_W-1:0] mult;

    // step 1 multiplies the low half, step 2 the high half, step 3 adds
    assign half = (step_reg == 2'd1) ? a_reg[HALF_W-1:0] : a_reg[DATA_W-1:HALF_W];
    assign mult = PART_W'(half) * PART_W'(NS_PER_SEC);

    always_comb
    begin
        step_next = step_reg;
        if (start)
        begin
            step_next = 2'd1;
        end
        else if (step_reg != 2'd0)
        begin
            step_next = step_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= 2'd0;
            done_reg <= 1'b0;
        end
        else
        begin
            step_reg <= step_next;
            done_reg <= (step_reg == 2'd3);
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg <= operand;
        end
        case (step_reg)
            2'd1:
            begin
                p_reg <= mult;
            end
            2'd2:
            begin
                acc_reg <= PROD_W'(p_reg);
                p_reg   <= mult;
            end
            2'd3:
            begin
                acc_reg <= acc_reg + (PROD_W'(p_reg) << HALF_W);
            end
            default:
            begin
            end
        endcase
    end

    assign done    = done_reg;
    assign product = acc_reg;

endmodule

### sv/lcrm_div.sv
// Restoring 128 / 64 divider, one quotient bit per cycle, saturating at 64 bits.
module lcrm_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [lcrm_pkg::DATA_W-1:0] dividend_hi,
    input  logic [lcrm_pkg::DATA_W-1:0] dividend_lo,
    input  logic [lcrm_pkg::DATA_W-1:0] divisor,
    output logic                        done,
    output logic [lcrm_pkg::DATA_W-1:0] quotient
);
    import lcrm_pkg::*;

    logic                 busy_reg;
    logic                 done_reg;
    logic [QUO_CNT_W-1:0] cnt_reg;
    logic [DATA_W-1:0]    rem_reg;
    logic [DATA_W-1:0]    lo_reg;
    logic [DATA_W-1:0]    dsr_reg;
    logic [DATA_W:0]      shifted;
    logic [DATA_W:0]      diff;
    logic                 ge;
    logic                 sat;

    assign sat     = (dividend_hi >= divisor);
    assign shifted = {rem_reg, lo_reg[DATA_W-1]};
    assign diff    = shifted - {1'b0, dsr_reg};
    assign ge      = !diff[DATA_W];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= !sat;
                done_reg <= sat;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == {QUO_CNT_W{1'b1}})
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // quotient bits shift into the low word as dividend bits leave it
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= dividend_hi;
            lo_reg  <= sat ? {DATA_W{1'b1}} : dividend_lo;
            dsr_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? diff[DATA_W-1:0] : shifted[DATA_W-1:0];
            lo_reg  <= {lo_reg[DATA_W-2:0], ge};
        end
    end

    assign done     = done_reg;
    assign quotient = lo_reg;

endmodule

### dv/rate_meter_checker.sv
// Checker for the link counter rate meter: watches all channels, predicts and compares results.
module rate_meter_checker (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             smp_valid,
    input  logic                             smp_stall,
    input  lcrm_pkg::sample_t                smp,
    input  logic                             res_valid,
    input  logic                             res_stall,
    input  lcrm_pkg::result_t                res,
    input  logic                             cfg_valid,
    input  logic                             cfg_ready,
    input  logic [lcrm_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [lcrm_pkg::DATA_W-1:0]      cfg_data,
    output int                               fail_count,
    output int                               pending_results
);
    timeunit 1ns;
    timeprecision 1ps;
    import lcrm_pkg::*;

    localparam logic [63:0] BITS_PER_SEC_SCALE    = 64'd8_000_000_000;
    localparam logic [63:0] PACKETS_PER_SEC_SCALE = 64'd1_000_000_000;

    logic        fwd_uses_rx;
    logic [63:0] gap_limit_ns;
    sample_t     last_sample;
    logic [31:0] epoch;
    result_t     awaited_results[$];
    int          mismatches;

    // floor(delta * scale / dt) at 128 bits, saturated to 64 bits
    function automatic logic [63:0] per_second(input logic [63:0] delta,
                                               input logic [63:0] scale,
                                               input logic [63:0] dt_ns);
        logic [127:0] quotient;
        quotient = ({64'd0, delta} * {64'd0, scale}) / {64'd0, dt_ns};
        return (quotient[127:64] != 64'd0) ? '1 : quotient[63:0];
    endfunction

    // gap class and rates of a sample against the stored one; epoch is filled in by the caller
    function automatic result_t classify_and_rate(input sample_t s);
        result_t     r;
        logic [63:0] dt_ns;
        logic [63:0] rx_b, tx_b, rx_p, tx_p;
        r = '0;
        if (!s.sample_valid)
        begin
            r.gap_code    = GAP_INVALID;
            r.reason_echo = s.invalid_reason;
        end
        else if (!last_sample.sample_valid)
            r.gap_code = GAP_FIRST;
        else if (s.identity_tag != last_sample.identity_tag)
            r.gap_code = GAP_IDENTITY;
        else
        begin
            dt_ns = s.timestamp_ns - last_sample.timestamp_ns;
            if (s.timestamp_ns <= last_sample.timestamp_ns || dt_ns > gap_limit_ns)
                r.gap_code = GAP_TIME;
            // any counter going backwards wins over a time gap
            if (s.rx_bytes < last_sample.rx_bytes || s.tx_bytes < last_sample.tx_bytes ||
                s.rx_packets < last_sample.rx_packets ||
                s.tx_packets < last_sample.tx_packets ||
                s.rx_errors < last_sample.rx_errors || s.tx_errors < last_sample.tx_errors ||
                s.rx_dropped < last_sample.rx_dropped ||
                s.tx_dropped < last_sample.tx_dropped)
                r.gap_code = GAP_RESET;
            if (r.gap_code == GAP_NONE)
            begin
                rx_b = s.rx_bytes - last_sample.rx_bytes;
                tx_b = s.tx_bytes - last_sample.tx_bytes;
                rx_p = s.rx_packets - last_sample.rx_packets;
                tx_p = s.tx_packets - last_sample.tx_packets;
                r.rates_valid         = 1'b1;
                r.forward_bits_rate   = per_second(fwd_uses_rx ? rx_b : tx_b,
                                                   BITS_PER_SEC_SCALE, dt_ns);
                r.reverse_bits_rate   = per_second(fwd_uses_rx ? tx_b : rx_b,
                                                   BITS_PER_SEC_SCALE, dt_ns);
                r.forward_packet_rate = per_second(fwd_uses_rx ? rx_p : tx_p,
                                                   PACKETS_PER_SEC_SCALE, dt_ns);
                r.reverse_packet_rate = per_second(fwd_uses_rx ? tx_p : rx_p,
                                                   PACKETS_PER_SEC_SCALE, dt_ns);
            end
        end
        return r;
    endfunction

    task automatic compare_field(input string name, input logic [63:0] want,
                                 input logic [63:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0h, actual %0h", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        if (!rst_n)
        begin
            fwd_uses_rx  = 1'b1;
            gap_limit_ns = MAX_GAP_RESET;
            last_sample  = '0;
            epoch        = '0;
            mismatches   = 0;
            awaited_results.delete();
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_FORWARD_IS_RX)
                    fwd_uses_rx = cfg_data[0];
                else if (cfg_index == CFG_MAX_GAP_NS)
                    gap_limit_ns = cfg_data;
            end
            if (smp_valid && !smp_stall)
            begin
                want = classify_and_rate(smp);
                if (want.gap_code != GAP_NONE)
                    epoch = epoch + 32'd1;
                want.epoch_count = epoch;
                // every sample is kept, invalid ones included
                last_sample = smp;
                awaited_results.push_back(want);
            end
            if (res_valid && !res_stall)
            begin
                if (awaited_results.size() == 0)
                begin
                    $error("result transaction with no sample pending");
                    mismatches++;
                end
                else
                begin
                    want = awaited_results.pop_front();
                    compare_field("gap_code", 64'(want.gap_code), 64'(res.gap_code));
                    compare_field("reason_echo", 64'(want.reason_echo), 64'(res.reason_echo));
                    compare_field("rates_valid", 64'(want.rates_valid), 64'(res.rates_valid));
                    compare_field("forward_bits_rate", want.forward_bits_rate,
                                  res.forward_bits_rate);
                    compare_field("reverse_bits_rate", want.reverse_bits_rate,
                                  res.reverse_bits_rate);
                    compare_field("forward_packet_rate", want.forward_packet_rate,
                                  res.forward_packet_rate);
                    compare_field("reverse_packet_rate", want.reverse_packet_rate,
                                  res.reverse_packet_rate);
                    compare_field("epoch_count", 64'(want.epoch_count), 64'(res.epoch_count));
                end
            end
        end
        fail_count      <= mismatches;
        pending_results <= awaited_results.size();
    end

endmodule

### dv/testbench.sv
// Testbench top for the link counter rate meter: clock, reset, stimulus, watchdog and verdict.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import lcrm_pkg::*;

    localparam int          WATCHDOG_LIMIT = 5000;
    localparam int          DRAIN_CYCLES   = 400;
    localparam int          NUM_PHASES     = 7;
    localparam int          BURST_PHASE    = 5;
    localparam int          NUM_CFG_REGS   = 2;
    localparam int          LAST_CFG_INDEX = (1 << CFG_INDEX_W) - 1;
    localparam logic [63:0] ONE_SECOND_NS  = 64'd1_000_000_000;
    localparam logic [63:0] DT_SPAN_CAP    = 64'd4_000_000_000;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   smp_valid = 1'b0;
    logic                   smp_stall;
    sample_t                smp = '0;
    logic                   res_valid;
    logic                   res_stall = 1'b0;
    result_t                res;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [DATA_W-1:0]      cfg_data = '0;
    int                     fail_count;
    int                     pending_results;

    logic                   burst_mode = 1'b0;
    logic [63:0]            gap_limit = MAX_GAP_RESET;
    sample_t                last_sent = '0;
    int                     quiet_cycles = 0;

    always #6 clk = ~clk;

    link_counter_rate_meter dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .smp_valid (smp_valid),
        .smp_stall (smp_stall),
        .smp       (smp),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    rate_meter_checker result_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .smp_valid       (smp_valid),
        .smp_stall       (smp_stall),
        .smp             (smp),
        .res_valid       (res_valid),
        .res_stall       (res_stall),
        .res             (res),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .fail_count      (fail_count),
        .pending_results (pending_results)
    );

    always @(posedge clk)
        res_stall <= !burst_mode && ($urandom_range(99) < 29);

    always @(posedge clk)
    begin
        if (!rst_n || (smp_valid && !smp_stall) || (res_valid && !res_stall) ||
            (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [63:0] pick_dt();
        logic [63:0] span;
        span = (gap_limit > DT_SPAN_CAP) ? DT_SPAN_CAP : gap_limit;
        case ($urandom_range(9))
            0:       return 64'd1;
            1:       return gap_limit;
            2:       return gap_limit + 64'd1;
            3:       return rand64();
            default: return (span == 64'd0) ? 64'd1 : 64'd1 + rand64() % span;
        endcase
    endfunction

    function automatic logic [63:0] pick_bytes();
        case ($urandom_range(9))
            0:       return 64'd0;
            1:       return rand64() >> $urandom_range(63);
            default: return 64'($urandom_range(2_000_000_000));
        endcase
    endfunction

    function automatic logic [63:0] pick_packets();
        case ($urandom_range(9))
            0:       return 64'd0;
            1:       return rand64() >> $urandom_range(20, 63);
            default: return 64'($urandom_range(2_000_000));
        endcase
    endfunction

    function automatic sample_t random_sample();
        sample_t s;
        s                = '0;
        s.sample_valid   = 1'($urandom_range(1));
        s.invalid_reason = 4'($urandom_range(15));
        s.identity_tag   = rand64();
        s.timestamp_ns   = rand64();
        for (int k = 0; k < NUM_CTR; k++)
            s[64*k +: 64] = rand64() >> ($urandom_range(3) * 16);
        return s;
    endfunction

    // well-formed follow-on sample: same identity, time advanced by dt, counters moving up
    function automatic sample_t grow(input sample_t base, input logic [63:0] dt,
                                     input logic [63:0] bytes, input logic [63:0] pkts);
        sample_t s;
        s = base;
        s.sample_valid  = 1'b1;
        s.timestamp_ns += dt;
        s.rx_bytes     += bytes;
        s.tx_bytes     += bytes >> 1;
        s.rx_packets   += pkts;
        s.tx_packets   += pkts >> 2;
        s.rx_errors    += pkts >> 12;
        s.tx_errors    += pkts >> 14;
        s.rx_dropped   += pkts >> 10;
        s.tx_dropped   += pkts >> 16;
        return s;
    endfunction

    task automatic send_sample(input sample_t s);
        while (!burst_mode && $urandom_range(99) < 29)
        begin
            smp_valid <= 1'b0;
            @(posedge clk);
        end
        smp       <= s;
        smp_valid <= 1'b1;
        @(posedge clk);
        while (smp_stall)
            @(posedge clk);
        last_sent = s;
    endtask

    task automatic send_next(input logic [63:0] dt, input logic [63:0] bytes,
                             input logic [63:0] pkts);
        send_sample(grow(last_sent, dt, bytes, pkts));
    endtask

    task automatic wait_drain();
        smp_valid <= 1'b0;
        @(posedge clk);
        while (pending_results != 0)
            @(posedge clk);
    endtask

    task automatic cfg_write(input logic [CFG_INDEX_W-1:0] index, input logic [63:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
    endtask

    // registers only change with the pipe empty; a write to an unused index goes along
    task automatic set_config(input logic fwd_rx, input logic [63:0] limit);
        wait_drain();
        cfg_write(CFG_FORWARD_IS_RX, {63'd0, fwd_rx});
        cfg_write(CFG_INDEX_W'($urandom_range(NUM_CFG_REGS, LAST_CFG_INDEX)), rand64());
        cfg_write(CFG_MAX_GAP_NS, limit);
        cfg_valid <= 1'b0;
        gap_limit = limit;
    endtask

    task automatic random_item();
        sample_t s;
        int      pick;
        int      k;
        pick = $urandom_range(99);
        k    = $urandom_range(NUM_CTR - 1);
        s    = grow(last_sent, pick_dt(), pick_bytes(), pick_packets());
        if (pick < 78)
        begin
        end
        else if (pick < 83)
        begin
            s                = random_sample();
            s.sample_valid   = 1'b0;
        end
        else if (pick < 87)
            s.identity_tag ^= rand64() | 64'd1;
        else if (pick < 91)
            // counters sit in the low eight 64-bit words of the packed sample
            s[64*k +: 64] = last_sent[64*k +: 64] - 64'($urandom_range(1, 3));
        else if (pick < 95)
            s.timestamp_ns = last_sent.timestamp_ns - 64'($urandom_range(3));
        else
            s = random_sample();
        send_sample(s);
    endtask

    initial
    begin
        sample_t     s;
        logic        fwd_rx;
        logic [63:0] limit;
        int          items;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset register values: source unavailable, then the highest reason code
        s                = random_sample();
        s.sample_valid   = 1'b0;
        s.invalid_reason = 4'd0;
        send_sample(s);
        s.invalid_reason = 4'hf;
        send_sample(s);

        s              = '0;
        s.sample_valid = 1'b1;
        s.identity_tag = rand64();
        s.timestamp_ns = 64'd1000;
        s.rx_errors    = 64'd100;
        s.tx_errors    = 64'd100;
        s.rx_dropped   = 64'd100;
        s.tx_dropped   = 64'd100;
        send_sample(s);
        send_next(ONE_SECOND_NS, 64'd125_000_000, 64'd1000);
        send_next(MAX_GAP_RESET, 64'd7, 64'd3);
        send_next(MAX_GAP_RESET + 64'd1, 64'd7, 64'd3);
        send_next(64'd0, 64'd10, 64'd1);
        send_next(64'd500, 64'd1_000_000, 64'd4096);

        s = grow(last_sent, ONE_SECOND_NS, 64'd1, 64'd1);
        s.identity_tag = ~s.identity_tag;
        send_sample(s);
        send_next(ONE_SECOND_NS, 64'd0, 64'd0);

        s = grow(last_sent, 64'd1_000_000, 64'd10, 64'd10);
        s.tx_dropped = last_sent.tx_dropped - 64'd1;
        send_sample(s);

        // counter decrease together with time going backwards
        s = grow(last_sent, 64'd0, 64'd10, 64'd10);
        s.timestamp_ns = last_sent.timestamp_ns - 64'd5;
        s.rx_bytes     = last_sent.rx_bytes - 64'd1;
        send_sample(s);

        // one nanosecond with huge deltas saturates every rate
        send_next(64'd1, 64'h8000_0000_0000_0000, 64'h0000_0100_0000_0000);

        set_config(1'b0, '1);
        s = last_sent;
        s.timestamp_ns = 64'd0;
        send_sample(s);
        send_next('1, 64'h0000_0001_0000_0000, 64'd1 << 33);

        set_config(1'b1, 64'd0);
        send_next(64'd1, 64'd5, 64'd5);

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            case (p)
                0:
                begin
                    fwd_rx = 1'b1;
                    limit  = MAX_GAP_RESET;
                    items  = 240;
                end
                1:
                begin
                    fwd_rx = 1'b0;
                    limit  = '1;
                    items  = 240;
                end
                2:
                begin
                    fwd_rx = 1'b1;
                    limit  = 64'd1;
                    items  = 200;
                end
                3:
                begin
                    fwd_rx = 1'b0;
                    limit  = rand64() >> $urandom_range(20, 40);
                    items  = 220;
                end
                4:
                begin
                    fwd_rx = 1'b1;
                    limit  = 64'd0;
                    items  = 60;
                end
                5:
                begin
                    fwd_rx = 1'b0;
                    limit  = MAX_GAP_RESET;
                    items  = 240;
                end
                default:
                begin
                    fwd_rx = 1'b1;
                    limit  = rand64();
                    items  = 220;
                end
            endcase
            set_config(fwd_rx, limit);
            burst_mode <= (p == BURST_PHASE);
            for (int i = 0; i < items; i++)
            begin
                if (i == items / 2)
                    wait_drain();
                random_item();
            end
        end

        burst_mode <= 1'b0;
        wait_drain();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending_results == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
